@@ sv/i2cm_pkg.sv @@
// Package: shared types and constants for the I2C master bit engine.
package i2cm_pkg;

  // Command codes
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_ACK   = 3'd5;
  localparam logic [2:0] CMD_NACK  = 3'd6;
  localparam logic [2:0] CMD_CHECK = 3'd7;

  // Sequence segment numbers
  localparam logic [3:0] SEG_IDLE  = 4'd0;
  localparam logic [3:0] SEG_ONE   = 4'd1;
  localparam logic [3:0] SEG_TWO   = 4'd2;
  localparam logic [3:0] SEG_THREE = 4'd3;
  localparam logic [3:0] SEG_FOUR  = 4'd4;

  localparam logic [2:0]  MSB_IDX         = 3'd7;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd1;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_bit;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  step;
    logic [2:0]  cmd;
    logic [3:0]  bit_idx;
    logic [7:0]  shift;
    logic [15:0] tick;
    logic        scl;
    logic        sda;
    logic        ack;
    logic [7:0]  rd_byte;
  } seq_state_t;

  localparam seq_state_t SEQ_STATE_RST = '{
    step:    SEG_IDLE,
    cmd:     CMD_NONE,
    bit_idx: 4'd0,
    shift:   8'd0,
    tick:    16'd0,
    scl:     1'b1,
    sda:     1'b1,
    ack:     1'b0,
    rd_byte: 8'd0
  };

endpackage

@@ sv/i2cm_step.sv @@
// Next-state and per-tick result logic of the I2C bus sequencer.
module i2cm_step import i2cm_pkg::*; (
  input  seq_state_t  cur_state,
  input  in_item_t    in_item,
  input  logic [15:0] phase_ticks,
  output seq_state_t  nxt_state,
  output out_item_t   result
);

  logic [15:0] hold;
  logic [3:0]  seg;
  logic        enter;
  logic        seg_ok;
  logic        busy;
  logic        done;
  seq_state_t  st;

  // zero phase length behaves as one tick
  assign hold = (phase_ticks == 16'd0) ? 16'd0 : phase_ticks - 16'd1;

  always_comb begin
    st     = cur_state;
    seg    = SEG_IDLE;
    enter  = 1'b0;
    seg_ok = 1'b0;
    busy   = 1'b0;
    done   = 1'b0;

    if (cur_state.step == SEG_IDLE) begin
      if (in_item.command != CMD_NONE) begin
        st.cmd     = in_item.command;
        st.bit_idx = 4'd0;
        st.shift   = (in_item.command == CMD_WRITE) ? in_item.data_byte : 8'd0;
        seg        = SEG_ONE;
        enter      = 1'b1;
      end
    end else if (cur_state.tick != 16'd0) begin
      st.tick = cur_state.tick - 16'd1;
      busy    = 1'b1;
    end else begin
      enter = 1'b1;
      if (cur_state.cmd == CMD_WRITE && cur_state.step == SEG_THREE) begin
        st.bit_idx = cur_state.bit_idx + 4'd1;
        seg        = SEG_TWO;
      end else if (cur_state.cmd == CMD_READ && cur_state.step == SEG_TWO) begin
        seg = SEG_ONE;
      end else begin
        seg = cur_state.step + 4'd1;
      end
    end

    if (enter) begin
      st.step = seg;
      case (st.cmd)
        CMD_START: begin
          if (seg == SEG_ONE) begin
            st.sda = 1'b1; st.scl = 1'b1; seg_ok = 1'b1;
          end else if (seg == SEG_TWO) begin
            st.sda = 1'b0; seg_ok = 1'b1;
          end
        end
        CMD_STOP: begin
          if (seg == SEG_ONE) begin
            st.sda = 1'b0; st.scl = 1'b1; seg_ok = 1'b1;
          end else if (seg == SEG_TWO) begin
            st.sda = 1'b1; seg_ok = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (seg == SEG_ONE) begin
            st.scl = 1'b0; seg_ok = 1'b1;
          end else if (seg == SEG_TWO) begin
            st.scl = 1'b0;
            if (!st.bit_idx[3]) begin
              st.sda = st.shift[MSB_IDX - st.bit_idx[2:0]];
              seg_ok = 1'b1;
            end
          end else if (seg == SEG_THREE) begin
            st.scl = 1'b1; seg_ok = 1'b1;
          end
        end
        CMD_READ: begin
          if (seg == SEG_ONE) begin
            if (st.bit_idx[3]) begin
              st.rd_byte = st.shift;
            end else begin
              st.scl = 1'b0; st.sda = 1'b1; seg_ok = 1'b1;
            end
          end else if (seg == SEG_TWO) begin
            st.scl     = 1'b1;
            st.shift   = {st.shift[6:0], in_item.sda_in};
            st.bit_idx = st.bit_idx + 4'd1;
            seg_ok     = 1'b1;
          end
        end
        CMD_ACK, CMD_NACK: begin
          if (seg == SEG_ONE) begin
            st.scl = 1'b0; seg_ok = 1'b1;
          end else if (seg == SEG_TWO) begin
            st.sda = (st.cmd == CMD_ACK) ? 1'b0 : 1'b1; seg_ok = 1'b1;
          end else if (seg == SEG_THREE) begin
            st.scl = 1'b1; seg_ok = 1'b1;
          end else if (seg == SEG_FOUR) begin
            st.scl = 1'b0; seg_ok = 1'b1;
          end else if (st.cmd == CMD_ACK) begin
            st.sda = 1'b1;  // release SDA after the ACK clock
          end
        end
        CMD_CHECK: begin
          if (seg == SEG_ONE) begin
            st.sda = 1'b1; seg_ok = 1'b1;
          end else if (seg == SEG_TWO) begin
            st.scl = 1'b1; seg_ok = 1'b1;
          end else if (seg == SEG_THREE) begin
            st.ack = in_item.sda_in; st.scl = 1'b0; seg_ok = 1'b1;
          end
        end
        default: seg_ok = 1'b0;
      endcase

      if (seg_ok) begin
        st.tick = hold;
        busy    = 1'b1;
      end else begin
        st.step = SEG_IDLE;
        done    = 1'b1;
      end
    end
  end

  assign nxt_state = st;

  assign result = '{
    scl_level: st.scl,
    sda_level: st.sda,
    busy_res:  busy,
    done_res:  done,
    read_data: st.rd_byte,
    ack_bit:   st.ack
  };

endmodule

@@ sv/i2cm_out_stage.sv @@
// Result register with valid/ready handshake towards the consumer.
module i2cm_out_stage import i2cm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_item,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_item,
  output logic      can_load
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  // register may be refilled in the same cycle it is drained
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

@@ sv/i2c_master_bit_engine.sv @@
// Top level of the I2C master bit engine: sequencer state, config and result stage.
// Usage
//  - Input channel (in_valid/in_ready/in_item): one transaction per timing tick.
//    It carries the sampled SDA level and, when the engine is idle, a command
//    (start, stop, write byte, read byte, send ACK, send NACK, check ACK).
//    Commands presented while busy are ignored, including on the done tick.
//  - Output channel (out_valid/out_ready/out_item): exactly one transaction per
//    input transaction, giving SCL/SDA drive levels, busy, done, read byte, ACK.
//  - cfg_we/cfg_wdata write phase_ticks (ticks per bus phase, 0 acts as 1).
//    Write only while the engine is idle.
// Timing
//  - The result is registered: it appears in the cycle after the input transaction is accepted.
//  - One transaction per cycle sustained while out_ready is high: the sequencer
//    step is one short combinational pass between state and result registers.
// Reset
//  - Synchronous, active-low rst_n: engine idle, SCL/SDA released,
//    phase_ticks = 1, read byte and ACK bit cleared, result stage empty.
// Back-pressure
//  - When out_ready is low with a result held, in_ready drops and the
//    sequencer state freezes until the result is taken.
module i2c_master_bit_engine import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  seq_state_t  state_r;
  seq_state_t  state_nxt;
  logic [15:0] phase_ticks_r;
  out_item_t   step_result;
  logic        accept;
  logic        can_load;

  assign in_ready = can_load;
  assign accept   = in_valid && can_load;

  // Phase length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  // Sequencer state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_STATE_RST;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  i2cm_step u_step (
    .cur_state   (state_r),
    .in_item     (in_item),
    .phase_ticks (phase_ticks_r),
    .nxt_state   (state_nxt),
    .result      (step_result)
  );

  i2cm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_item (step_result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .can_load  (can_load)
  );

endmodule

@@ sim/i2c_master_bit_engine_tb.sv @@
// Testbench for the I2C master bit engine: directed table, random ticks, self-checking.
`timescale 1ns / 100ps

module i2c_master_bit_engine_tb import i2cm_pkg::*; ();

  // Watchdog: cycles with no transaction on either channel before giving up.
  // Longest legitimate quiet spell is the receiver hold-off or a config pause.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned RX_HOLD_CYC = 250;
  localparam int unsigned N_ROWS      = 20;
  localparam int unsigned N_PHASES    = 5;
  localparam int unsigned SEG_ITEMS   = 300;

  typedef struct packed {
    in_item_t  it;
    logic      pad;    // feed idle ticks afterwards until the engine is idle again
    logic      typed;  // expected result given in the row, not predicted
    out_item_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  i2c_master_bit_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bus sequencer model: own copy of the engine state and phase length.
  // ---------------------------------------------------------------------------
  logic [15:0] phase_len = PHASE_TICKS_RST;
  logic [3:0]  seg       = SEG_IDLE;
  logic [2:0]  cur_cmd   = CMD_NONE;
  logic [3:0]  bit_cnt   = '0;
  logic [7:0]  shreg     = '0;
  logic [15:0] phase_left = '0;
  logic        scl_q = 1'b1;
  logic        sda_q = 1'b1;
  logic        ack_q = 1'b0;
  logic [7:0]  rd_q  = '0;

  // Expected bus levels, oldest first
  out_item_t   bus_levels_q[$];
  int unsigned err_cnt = 0;

  // Zero phase length behaves as one tick per phase
  function automatic logic [15:0] phase_hold();
    return (phase_len == 16'd0) ? 16'd0 : phase_len - 16'd1;
  endfunction

  // Apply the pin actions of segment s; 1 means the segment holds for a phase
  function automatic logic enter_seg(input logic [3:0] s, input logic sda);
    case (cur_cmd)
      CMD_START: begin
        if (s == SEG_ONE) begin
          sda_q = 1'b1;
          scl_q = 1'b1;
          return 1'b1;
        end
        if (s == SEG_TWO) begin
          sda_q = 1'b0;
          return 1'b1;
        end
        return 1'b0;
      end
      CMD_STOP: begin
        if (s == SEG_ONE) begin
          sda_q = 1'b0;
          scl_q = 1'b1;
          return 1'b1;
        end
        if (s == SEG_TWO) begin
          sda_q = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      CMD_WRITE: begin
        if (s == SEG_ONE) begin
          scl_q = 1'b0;
          return 1'b1;
        end
        if (s == SEG_TWO) begin
          scl_q = 1'b0;
          if (bit_cnt >= 4'd8) return 1'b0;
          sda_q = shreg[MSB_IDX - bit_cnt[2:0]];
          return 1'b1;
        end
        if (s == SEG_THREE) begin
          scl_q = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      CMD_READ: begin
        if (s == SEG_ONE) begin
          if (bit_cnt >= 4'd8) begin
            rd_q = shreg;
            return 1'b0;
          end
          scl_q = 1'b0;
          sda_q = 1'b1;
          return 1'b1;
        end
        if (s == SEG_TWO) begin
          // sample on the rising SCL phase
          scl_q = 1'b1;
          shreg = {shreg[6:0], sda};
          bit_cnt = bit_cnt + 4'd1;
          return 1'b1;
        end
        return 1'b0;
      end
      CMD_ACK, CMD_NACK: begin
        if (s == SEG_ONE) begin
          scl_q = 1'b0;
          return 1'b1;
        end
        if (s == SEG_TWO) begin
          sda_q = (cur_cmd == CMD_ACK) ? 1'b0 : 1'b1;
          return 1'b1;
        end
        if (s == SEG_THREE) begin
          scl_q = 1'b1;
          return 1'b1;
        end
        if (s == SEG_FOUR) begin
          scl_q = 1'b0;
          return 1'b1;
        end
        if (cur_cmd == CMD_ACK) sda_q = 1'b1;
        return 1'b0;
      end
      CMD_CHECK: begin
        if (s == SEG_ONE) begin
          sda_q = 1'b1;
          return 1'b1;
        end
        if (s == SEG_TWO) begin
          scl_q = 1'b1;
          return 1'b1;
        end
        if (s == SEG_THREE) begin
          ack_q = sda;
          scl_q = 1'b0;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Write loops segments two/three per bit, read loops one/two
  function automatic logic [3:0] next_seg(input logic [3:0] s);
    if (cur_cmd == CMD_WRITE && s == SEG_THREE) begin
      bit_cnt = bit_cnt + 4'd1;
      return SEG_TWO;
    end
    if (cur_cmd == CMD_READ && s == SEG_TWO) return SEG_ONE;
    return s + 4'd1;
  endfunction

  // One timing tick through the model: returns the bus levels it produces
  function automatic out_item_t step_bus(input in_item_t it);
    out_item_t r;
    logic      busy;
    logic      done;
    busy = 1'b0;
    done = 1'b0;
    if (seg == SEG_IDLE) begin
      if (it.command != CMD_NONE) begin
        cur_cmd = it.command;
        bit_cnt = '0;
        shreg = (it.command == CMD_WRITE) ? it.data_byte : 8'd0;
        seg = SEG_ONE;
        if (enter_seg(SEG_ONE, it.sda_in)) begin
          phase_left = phase_hold();
          busy = 1'b1;
        end else begin
          seg = SEG_IDLE;
          done = 1'b1;
        end
      end
    end else if (phase_left != 16'd0) begin
      phase_left = phase_left - 16'd1;
      busy = 1'b1;
    end else begin
      seg = next_seg(seg);
      if (enter_seg(seg, it.sda_in)) begin
        phase_left = phase_hold();
        busy = 1'b1;
      end else begin
        seg = SEG_IDLE;
        done = 1'b1;
      end
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.busy_res  = busy;
    r.done_res  = done;
    r.read_data = rd_q;
    r.ack_bit   = ack_q;
    return r;
  endfunction

  function automatic string fmt_levels(input out_item_t v);
    return $sformatf("scl=%0d sda=%0d busy=%0d done=%0d rd=%02h ack=%0d",
                     v.scl_level, v.sda_level, v.busy_res, v.done_res,
                     v.read_data, v.ack_bit);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of ticks with random gaps. The model is stepped at the
  // edge where the transaction is accepted, so its state is always current
  // for the next stimulus decision.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic send_tick(input in_item_t it, input logic typed, input out_item_t want);
    int unsigned gap;
    out_item_t   pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 15) == 0) ? 400 : $urandom_range(1, 48);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = step_bus(it);
    bus_levels_q.push_back(typed ? want : pred);
  endtask

  // Random tick: mostly commands while idle, mostly empty ticks while busy,
  // with the odd command thrown at a busy engine to check it is ignored.
  function automatic in_item_t rand_tick();
    in_item_t it;
    it.data_byte = 8'($urandom_range(0, 255));
    it.sda_in    = 1'($urandom_range(0, 1));
    if (seg == SEG_IDLE)
      it.command = ($urandom_range(0, 9) < 8) ?
                   3'($urandom_range(CMD_START, CMD_CHECK)) : CMD_NONE;
    else
      it.command = ($urandom_range(0, 19) == 0) ?
                   3'($urandom_range(CMD_START, CMD_CHECK)) : CMD_NONE;
    return it;
  endfunction

  // Finish the current command with random ticks
  task automatic run_to_idle();
    while (seg != SEG_IDLE) send_tick(rand_tick(), 1'b0, '0);
  endtask

  // Sender pauses until every result is back
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (bus_levels_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_phase(input logic [15:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    phase_len = v;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern cycling through modes, plus a long hold-off on
  // request so the result stage fills and the input stalls.
  // ---------------------------------------------------------------------------
  int unsigned rx_cyc = 0;
  int unsigned rx_hold_left = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;

  always @(posedge clk) begin
    rx_cyc++;
    if (hold_seen != hold_asks) begin
      hold_seen    = hold_asks;
      rx_hold_left = RX_HOLD_CYC;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_cyc[8:6])
        3'd0, 3'd1:       out_ready <= 1'b1;
        3'd2, 3'd3, 3'd4: out_ready <= ($urandom_range(0, 9) >= 3);
        3'd5, 3'd6:       out_ready <= ($urandom_range(0, 9) >= 7);
        default:          out_ready <= rx_cyc[0];
      endcase
    end
  end

  // Result checker: each result transaction against the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (bus_levels_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result: %s", fmt_levels(out_item));
      end else begin
        e = bus_levels_q.pop_front();
        if (out_item.scl_level !== e.scl_level || out_item.sda_level !== e.sda_level ||
            out_item.busy_res !== e.busy_res || out_item.done_res !== e.done_res ||
            out_item.read_data !== e.read_data || out_item.ack_bit !== e.ack_bit) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp %s / got %s", fmt_levels(e), fmt_levels(out_item));
        end
      end
    end
  end

  // Watchdog on quiet cycles
  int unsigned quiet_cyc = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cyc = 0;
    else
      quiet_cyc++;
    if (quiet_cyc >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic dir_row_t mk_row(input logic [2:0] cmd, input logic [7:0] data,
                                      input logic sda, input logic pad, input logic typed,
                                      input out_item_t want);
    dir_row_t r;
    r.it.command   = cmd;
    r.it.data_byte = data;
    r.it.sda_in    = sda;
    r.pad          = pad;
    r.typed        = typed;
    r.want         = want;
    return r;
  endfunction

  dir_row_t    dir_rows [N_ROWS];
  logic [15:0] phase_set [N_PHASES];
  in_item_t    pad_it;

  initial begin
    // Directed table at the reset phase length of one tick.
    // want = {scl, sda, busy, done, read byte, ack}
    dir_rows[0]  = mk_row(CMD_NONE,  8'h00, 1'b0, 1'b0, 1'b1, {4'b1100, 8'h00, 1'b0});
    dir_rows[1]  = mk_row(CMD_NONE,  8'hFF, 1'b1, 1'b0, 1'b1, {4'b1100, 8'h00, 1'b0});
    dir_rows[2]  = mk_row(CMD_START, 8'h00, 1'b0, 1'b0, 1'b1, {4'b1110, 8'h00, 1'b0});
    dir_rows[3]  = mk_row(CMD_NONE,  8'h00, 1'b1, 1'b0, 1'b1, {4'b1010, 8'h00, 1'b0});
    // stop offered on the done tick of the start: ignored
    dir_rows[4]  = mk_row(CMD_STOP,  8'hFF, 1'b1, 1'b0, 1'b1, {4'b1001, 8'h00, 1'b0});
    dir_rows[5]  = mk_row(CMD_STOP,  8'h00, 1'b0, 1'b1, 1'b0, '0);
    dir_rows[6]  = mk_row(CMD_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, '0);
    dir_rows[7]  = mk_row(CMD_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, '0);
    dir_rows[8]  = mk_row(CMD_WRITE, 8'hA5, 1'b0, 1'b1, 1'b0, '0);
    dir_rows[9]  = mk_row(CMD_READ,  8'h00, 1'b1, 1'b1, 1'b0, '0);
    dir_rows[10] = mk_row(CMD_READ,  8'hFF, 1'b0, 1'b1, 1'b0, '0);
    dir_rows[11] = mk_row(CMD_ACK,   8'h5A, 1'b1, 1'b1, 1'b0, '0);
    dir_rows[12] = mk_row(CMD_NACK,  8'h5A, 1'b0, 1'b1, 1'b0, '0);
    dir_rows[13] = mk_row(CMD_CHECK, 8'h00, 1'b1, 1'b1, 1'b0, '0);
    dir_rows[14] = mk_row(CMD_CHECK, 8'hFF, 1'b0, 1'b1, 1'b0, '0);
    // command while busy: the read must be ignored
    dir_rows[15] = mk_row(CMD_START, 8'h00, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[16] = mk_row(CMD_READ,  8'hFF, 1'b1, 1'b1, 1'b0, '0);
    dir_rows[17] = mk_row(CMD_WRITE, 8'h5A, 1'b1, 1'b1, 1'b0, '0);
    dir_rows[18] = mk_row(CMD_READ,  8'h3C, 1'b1, 1'b1, 1'b0, '0);
    dir_rows[19] = mk_row(CMD_NONE,  8'hFF, 1'b1, 1'b0, 1'b0, '0);

    // Phase settings for the random part; zero must behave as one
    phase_set[0] = 16'd0;
    phase_set[1] = 16'd2;
    phase_set[2] = 16'd1;
    phase_set[3] = 16'd3;
    phase_set[4] = 16'($urandom_range(4, 7));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_tick(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
      if (dir_rows[i].pad) begin
        pad_it = dir_rows[i].it;
        pad_it.command = CMD_NONE;
        while (seg != SEG_IDLE) send_tick(pad_it, 1'b0, '0);
      end
    end

    // Random ticks under each phase length
    for (int p = 0; p < N_PHASES; p++) begin
      run_to_idle();
      drain();
      set_phase(phase_set[p]);
      for (int k = 0; k < SEG_ITEMS; k++) begin
        // long receiver hold-off while the sender keeps offering ticks
        if (p == 2 && k == 100) hold_asks++;
        send_tick(rand_tick(), 1'b0, '0);
      end
    end

    // Long phase: one start condition run to completion
    run_to_idle();
    drain();
    set_phase(16'd60);
    pad_it = rand_tick();
    pad_it.command = CMD_START;
    send_tick(pad_it, 1'b0, '0);
    run_to_idle();

    drain();
    if (err_cnt == 0 && bus_levels_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
sv/i2cm_pkg.sv
sv/i2cm_step.sv
sv/i2cm_out_stage.sv
sv/i2c_master_bit_engine.sv
sim/i2c_master_bit_engine_tb.sv
